FILE: hdl/wac_pkg.sv
// Shared types and constants for the weekly alarm checker.
// Holds the sequencer states, alarm field positions, lamp codes and the evaluation flags.
// No dependencies.
package wac_pkg;

    // Number of alarms and their packed register width
    localparam int NUM_ALARMS = 4;
    localparam int ALARM_W    = 27;

    // Bit positions inside one packed alarm register
    localparam int ALM_MIN_LSB  = 0;
    localparam int ALM_HOUR_LSB = 8;
    localparam int ALM_DAYS_LSB = 16;
    localparam int ALM_ENABLE   = 23;
    localparam int ALM_RING     = 24;
    localparam int ALM_SNOOZE   = 25;
    localparam int ALM_SUNRISE  = 26;

    // Minute arithmetic constants
    localparam logic signed [15:0] DAY_MINUTES = 16'sd1440;
    localparam logic signed [15:0] LEAD_30     = 16'sd30;
    localparam logic signed [15:0] LEAD_22     = 16'sd22;
    localparam logic signed [15:0] LEAD_15     = 16'sd15;
    localparam logic signed [15:0] LEAD_7      = 16'sd7;
    localparam logic signed [15:0] LEAD_0      = 16'sd0;
    localparam logic signed [15:0] LAG_4       = -16'sd4;
    localparam logic signed [15:0] LAG_8       = -16'sd8;
    localparam logic signed [15:0] LAG_12      = -16'sd12;
    localparam logic signed [15:0] LAG_15      = -16'sd15;

    // Lamp brightness commands
    localparam logic [2:0] LAMP_NONE = 3'd0;
    localparam logic [2:0] LAMP_20   = 3'd1;
    localparam logic [2:0] LAMP_40   = 3'd2;
    localparam logic [2:0] LAMP_60   = 3'd3;
    localparam logic [2:0] LAMP_80   = 3'd4;
    localparam logic [2:0] LAMP_100  = 3'd5;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SNOOZE,
        ST_FINISH
    } wac_state_t;

    // Flags produced by the shared evaluation unit for one alarm
    typedef struct packed {
        logic hit_0;
        logic hit_7;
        logic hit_15;
        logic hit_22;
        logic hit_30;
        logic pending;
        logic snz_ring;
        logic snz_end;
    } wac_eval_t;

    // Decode one BCD byte as high*10 + low, for any nibble values
    function automatic logic [7:0] bcd_value(input logic [7:0] b);
        return ({4'b0000, b[7:4]} * 8'd10) + {4'b0000, b[3:0]};
    endfunction

endpackage

FILE: hdl/wac_eval.sv
// Shared evaluation unit: minutes between one alarm and the current time, and its trigger flags.
// Used once per cycle by the sequencer in the top level.
// Depends on wac_pkg.
module wac_eval (
    input  logic [wac_pkg::ALARM_W-1:0] alarm,
    input  logic [11:0]                 now_min,
    input  logic [2:0]                  weekday,
    output wac_pkg::wac_eval_t          flags
);

    logic [7:0]         hr_val;
    logic [7:0]         mn_val;
    logic [13:0]        alarm_min;
    logic signed [15:0] diff;
    logic signed [15:0] wrapped;
    logic signed [15:0] dd;
    logic [6:0]         days;
    logic [6:0]         today_mask;
    logic [6:0]         next_mask;
    logic               today_hit;
    logic               next_hit;
    logic               due_ok;
    logic               snz_ok;

    // Decode alarm time to minutes of day
    always_comb begin
        hr_val    = wac_pkg::bcd_value(alarm[wac_pkg::ALM_HOUR_LSB +: 8]);
        mn_val    = wac_pkg::bcd_value(alarm[wac_pkg::ALM_MIN_LSB +: 8]);
        alarm_min = (14'(hr_val) * 14'd60) + 14'(mn_val);
    end

    // Day masks for today and tomorrow; weekday zero has no today bit
    always_comb begin
        days       = alarm[wac_pkg::ALM_DAYS_LSB +: 7];
        today_mask = (weekday == 3'd0) ? 7'd0 : (7'd1 << (weekday - 3'd1));
        next_mask  = (weekday == 3'd7) ? 7'd1 : (7'd1 << weekday);
        today_hit  = |(days & today_mask);
        next_hit   = |(days & next_mask);
    end

    // Signed distance to the alarm, wrapped into the next day when past
    always_comb begin
        diff    = $signed({2'b00, alarm_min}) - $signed({4'b0000, now_min});
        wrapped = diff + wac_pkg::DAY_MINUTES;
        dd      = diff[15] ? wrapped : diff;
        due_ok  = alarm[wac_pkg::ALM_ENABLE] && (diff[15] ? next_hit : today_hit);
        snz_ok  = alarm[wac_pkg::ALM_ENABLE] && alarm[wac_pkg::ALM_SNOOZE] && today_hit;
    end

    // Trigger flags
    always_comb begin
        flags.hit_0    = due_ok && (dd == wac_pkg::LEAD_0);
        flags.hit_7    = due_ok && (dd == wac_pkg::LEAD_7);
        flags.hit_15   = due_ok && (dd == wac_pkg::LEAD_15);
        flags.hit_22   = due_ok && (dd == wac_pkg::LEAD_22);
        flags.hit_30   = due_ok && (dd == wac_pkg::LEAD_30);
        flags.pending  = due_ok && (dd > wac_pkg::LEAD_0);
        flags.snz_ring = snz_ok && ((diff == wac_pkg::LAG_4) || (diff == wac_pkg::LAG_8) ||
                                    (diff == wac_pkg::LAG_12));
        flags.snz_end  = snz_ok && (diff == wac_pkg::LAG_15);
    end

endmodule

FILE: hdl/weekly_alarm_checker_unit.sv
// Weekly alarm checker: one item per minute tick, four alarms walked by one evaluation unit.
// An item with alarms_off is accepted and gives nothing; otherwise the first three results leave
// from the evaluation states and the last from the finish state, after the snooze pass if any.
// A new item is taken only in idle, after the last result is registered; the shared evaluation
// unit handles one alarm per cycle unless an early result waits on a full output. Reset clears all flags,
// the alarm registers and the sequencer. Depends on wac_pkg and wac_eval.
module weekly_alarm_checker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [26:0] cfg_data,
    // Tick input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [5:0]  s_hour_bcd,
    input  logic [6:0]  s_minute_bcd,
    input  logic [2:0]  s_weekday,
    input  logic        s_alarms_off,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_alarm_index,
    output logic [2:0]  m_lamp_command,
    output logic        m_last_result,
    output logic        m_ringing,
    output logic        m_snooze_active,
    output logic        m_lamp_active,
    output logic        m_led_one,
    output logic        m_led_two
);

    wac_pkg::wac_state_t state_reg, state_next;
    logic [1:0]  idx_reg, idx_next;
    logic [11:0] now_reg, now_next;
    logic [2:0]  wd_reg, wd_next;
    logic [2:0]  lamp3_reg, lamp3_next;
    logic        pending_reg, pending_next;
    logic        ringing_reg, ringing_next;
    logic        snooze_reg, snooze_next;
    logic        lampf_reg, lampf_next;
    logic        dark_reg, dark_next;
    logic        led1_reg, led1_next;
    logic        led2_reg, led2_next;
    logic [wac_pkg::ALARM_W-1:0] alarm_reg [wac_pkg::NUM_ALARMS];

    // Output register
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_idx_reg, m_idx_next;
    logic [2:0]  m_lamp_reg, m_lamp_next;
    logic        m_last_reg, m_last_next;
    logic        m_ring_reg, m_ring_next;
    logic        m_snz_reg, m_snz_next;
    logic        m_lampf_reg, m_lampf_next;
    logic        m_led1_reg, m_led1_next;
    logic        m_led2_reg, m_led2_next;

    wac_pkg::wac_eval_t ev;
    logic [wac_pkg::ALARM_W-1:0] cur_alarm;
    logic        slot_free;
    logic        sunrise;
    logic [2:0]  lamp_cmd;
    logic        step_ring;
    logic        step_snooze;
    logic        ring_now;
    logic        snooze_now;
    logic        pend_now;
    logic [11:0] tick_min;

    // Shared evaluation unit on the alarm selected by the sequencer
    assign cur_alarm = alarm_reg[idx_reg];

    wac_eval u_eval (
        .alarm   (cur_alarm),
        .now_min (now_reg),
        .weekday (wd_reg),
        .flags   (ev)
    );

    // Convert the incoming BCD time to minutes of day
    always_comb begin
        tick_min = (12'(wac_pkg::bcd_value({2'b00, s_hour_bcd})) * 12'd60) +
                   12'(wac_pkg::bcd_value({1'b0, s_minute_bcd}));
    end

    // Lamp command and flag effects of the current alarm
    always_comb begin
        sunrise     = cur_alarm[wac_pkg::ALM_SUNRISE];
        step_ring   = ev.hit_0 && (cur_alarm[wac_pkg::ALM_RING] || cur_alarm[wac_pkg::ALM_SNOOZE]);
        step_snooze = ev.hit_0 && cur_alarm[wac_pkg::ALM_SNOOZE];
        lamp_cmd    = wac_pkg::LAMP_NONE;
        priority if (ev.hit_0) begin
            if (sunrise && dark_reg) lamp_cmd = wac_pkg::LAMP_100;
        end else if (ev.hit_7) begin
            if (sunrise && dark_reg) lamp_cmd = wac_pkg::LAMP_80;
        end else if (ev.hit_15) begin
            if (sunrise && dark_reg) lamp_cmd = wac_pkg::LAMP_60;
        end else if (ev.hit_22) begin
            if (sunrise && dark_reg) lamp_cmd = wac_pkg::LAMP_40;
        end else if (ev.hit_30) begin
            if (sunrise) lamp_cmd = wac_pkg::LAMP_20;
        end else begin
            lamp_cmd = wac_pkg::LAMP_NONE;
        end
        ring_now   = ringing_reg || step_ring;
        snooze_now = snooze_reg || step_snooze;
        pend_now   = pending_reg || ev.pending;
    end

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == wac_pkg::ST_IDLE);

    // Sequencer: next state and register updates
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        now_next     = now_reg;
        wd_next      = wd_reg;
        lamp3_next   = lamp3_reg;
        pending_next = pending_reg;
        ringing_next = ringing_reg;
        snooze_next  = snooze_reg;
        lampf_next   = lampf_reg;
        dark_next    = dark_reg;
        led1_next    = led1_reg;
        led2_next    = led2_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_idx_next   = m_idx_reg;
        m_lamp_next  = m_lamp_reg;
        m_last_next  = m_last_reg;
        m_ring_next  = m_ring_reg;
        m_snz_next   = m_snz_reg;
        m_lampf_next = m_lampf_reg;
        m_led1_next  = m_led1_reg;
        m_led2_next  = m_led2_reg;

        unique case (state_reg)
            wac_pkg::ST_IDLE: begin
                // Take a tick; drop it when alarms are off
                if (s_valid && !s_alarms_off) begin
                    now_next     = tick_min;
                    wd_next      = s_weekday;
                    ringing_next = 1'b0;
                    pending_next = 1'b0;
                    idx_next     = 2'd0;
                    state_next   = wac_pkg::ST_EVAL;
                end
            end
            wac_pkg::ST_EVAL: begin
                // Evaluate one alarm; hold until the output slot is free for early results
                if ((idx_reg == 2'd3) || slot_free) begin
                    ringing_next = ring_now;
                    snooze_next  = snooze_now;
                    pending_next = pend_now;
                    if (ev.hit_30 && sunrise) begin
                        dark_next  = 1'b1;
                        lampf_next = 1'b1;
                    end
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg != 2'd3) begin
                        m_valid_next = 1'b1;
                        m_idx_next   = idx_reg;
                        m_lamp_next  = lamp_cmd;
                        m_last_next  = 1'b0;
                        m_ring_next  = 1'b0;
                        m_snz_next   = 1'b0;
                        m_lampf_next = 1'b0;
                        m_led1_next  = 1'b0;
                        m_led2_next  = 1'b0;
                    end else begin
                        lamp3_next = lamp_cmd;
                        // Resolve LEDs or start the snooze pass
                        priority if (ring_now) begin
                            led1_next  = 1'b0;
                            led2_next  = 1'b0;
                            state_next = wac_pkg::ST_FINISH;
                        end else if (snooze_now) begin
                            state_next = wac_pkg::ST_SNOOZE;
                        end else if (pend_now) begin
                            led1_next  = 1'b1;
                            led2_next  = 1'b0;
                            state_next = wac_pkg::ST_FINISH;
                        end else begin
                            led1_next  = 1'b0;
                            led2_next  = 1'b1;
                            state_next = wac_pkg::ST_FINISH;
                        end
                    end
                end
            end
            wac_pkg::ST_SNOOZE: begin
                // Check re-ring times after each snooze alarm
                if (ev.snz_ring || ev.snz_end) ringing_next = 1'b1;
                if (ev.snz_end) snooze_next = 1'b0;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3) state_next = wac_pkg::ST_FINISH;
            end
            wac_pkg::ST_FINISH: begin
                // Emit the last result with the status fields
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = 2'd3;
                    m_lamp_next  = lamp3_reg;
                    m_last_next  = 1'b1;
                    m_ring_next  = ringing_reg;
                    m_snz_next   = snooze_reg;
                    m_lampf_next = lampf_reg;
                    m_led1_next  = led1_reg;
                    m_led2_next  = led2_reg;
                    state_next   = wac_pkg::ST_IDLE;
                end
            end
            default: state_next = wac_pkg::ST_IDLE;
        endcase
    end

    // Control and flag registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wac_pkg::ST_IDLE;
            idx_reg     <= 2'd0;
            pending_reg <= 1'b0;
            ringing_reg <= 1'b0;
            snooze_reg  <= 1'b0;
            lampf_reg   <= 1'b0;
            dark_reg    <= 1'b0;
            led1_reg    <= 1'b0;
            led2_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            pending_reg <= pending_next;
            ringing_reg <= ringing_next;
            snooze_reg  <= snooze_next;
            lampf_reg   <= lampf_next;
            dark_reg    <= dark_next;
            led1_reg    <= led1_next;
            led2_reg    <= led2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Alarm configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < wac_pkg::NUM_ALARMS; i++) begin
                alarm_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            alarm_reg[cfg_index] <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        now_reg      <= now_next;
        wd_reg       <= wd_next;
        lamp3_reg    <= lamp3_next;
        m_idx_reg    <= m_idx_next;
        m_lamp_reg   <= m_lamp_next;
        m_last_reg   <= m_last_next;
        m_ring_reg   <= m_ring_next;
        m_snz_reg    <= m_snz_next;
        m_lampf_reg  <= m_lampf_next;
        m_led1_reg   <= m_led1_next;
        m_led2_reg   <= m_led2_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_alarm_index   = m_idx_reg;
    assign m_lamp_command  = m_lamp_reg;
    assign m_last_result   = m_last_reg;
    assign m_ringing       = m_ring_reg;
    assign m_snooze_active = m_snz_reg;
    assign m_lamp_active   = m_lampf_reg;
    assign m_led_one       = m_led1_reg;
    assign m_led_two       = m_led2_reg;

    // The last item of a tick belongs to the fourth alarm
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_result) |-> (m_alarm_index == 2'd3))
        else $error("last result not from alarm three");

    // Early items carry no status
    a_early_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last_result) |->
        !(m_ringing || m_snooze_active || m_lamp_active || m_led_one || m_led_two))
        else $error("status set on an early result");

    // The two LEDs are never lit together
    a_led_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_result) |-> !(m_led_one && m_led_two))
        else $error("both LEDs lit");

    // A tick with alarms off leaves the block idle
    a_off_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_alarms_off) |=> s_ready)
        else $error("alarms-off tick started a walk");

endmodule

FILE: dv/alarm_tick_monitor.sv
// Alarm tick monitor: follows register writes and accepted ticks, predicts the four per-alarm
// results of each tick and compares every accepted result with the oldest prediction.
// Depends on wac_pkg for alarm field positions, lamp codes and the alarm count.
module alarm_tick_monitor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [26:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [5:0]  s_hour_bcd,
    input  logic [6:0]  s_minute_bcd,
    input  logic [2:0]  s_weekday,
    input  logic        s_alarms_off,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_alarm_index,
    input  logic [2:0]  m_lamp_command,
    input  logic        m_last_result,
    input  logic        m_ringing,
    input  logic        m_snooze_active,
    input  logic        m_lamp_active,
    input  logic        m_led_one,
    input  logic        m_led_two,
    output int          fail_count,
    output int          outstanding
);

    typedef struct packed {
        logic [1:0] index;
        logic [2:0] lamp;
        logic       last;
        logic       ring;
        logic       snooze;
        logic       lamp_lit;
        logic       led_one;
        logic       led_two;
    } alarm_result_t;

    localparam int NOT_DUE = -1;
    localparam int DAY_LEN = 24 * 60;

    // Predictor copy of the alarm registers and the block's flags
    logic [26:0]   alarm_cfg [wac_pkg::NUM_ALARMS];
    logic          ring_now;
    logic          snooze_seq;
    logic          lamp_on;
    logic          dusk_seen;
    logic          led_pending;
    logic          led_idle;
    alarm_result_t queued_alarm_results [$];
    alarm_result_t want;
    int            errors = 0;

    function automatic int decode_bcd(input logic [7:0] b);
        return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function automatic int alarm_clock_minutes(input logic [26:0] a);
        return decode_bcd(a[wac_pkg::ALM_HOUR_LSB +: 8]) * 60 +
               decode_bcd(a[wac_pkg::ALM_MIN_LSB +: 8]);
    endfunction

    // Day mask bit for today; weekday zero matches nothing
    function automatic logic [6:0] today_mask(input logic [2:0] wd);
        if (wd == 3'd0) begin
            return 7'b0;
        end
        return 7'b1 << (wd - 3'd1);
    endfunction

    // Day mask bit for tomorrow; weekday seven wraps to the first day
    function automatic logic [6:0] next_mask(input logic [2:0] wd);
        if (wd == 3'd7) begin
            return 7'b1;
        end
        return 7'b1 << wd;
    endfunction

    // Minutes until the alarm, rolling into the next day when today's time is past
    function automatic int lead_minutes(input logic [26:0] a, input int now,
                                        input logic [2:0] wd);
        int d;
        if (!a[wac_pkg::ALM_ENABLE]) begin
            return NOT_DUE;
        end
        d = alarm_clock_minutes(a) - now;
        if (d < 0) begin
            return ((a[wac_pkg::ALM_DAYS_LSB +: 7] & next_mask(wd)) != 0) ?
                   d + DAY_LEN : NOT_DUE;
        end
        return ((a[wac_pkg::ALM_DAYS_LSB +: 7] & today_mask(wd)) != 0) ? d : NOT_DUE;
    endfunction

    // Minutes since the alarm time, for enabled snooze alarms due today
    function automatic int lag_minutes(input logic [26:0] a, input int now,
                                       input logic [2:0] wd);
        if (!a[wac_pkg::ALM_ENABLE] || !a[wac_pkg::ALM_SNOOZE]) begin
            return NOT_DUE;
        end
        if ((a[wac_pkg::ALM_DAYS_LSB +: 7] & today_mask(wd)) == 0) begin
            return NOT_DUE;
        end
        return now - alarm_clock_minutes(a);
    endfunction

    // Walk the four alarms for one tick and queue their results
    task automatic predict_alarm_tick(input logic [5:0] hr, input logic [6:0] mn,
                                      input logic [2:0] wd);
        alarm_result_t res [wac_pkg::NUM_ALARMS];
        int            now;
        int            lead;
        int            lag;
        int            i;
        logic          pending;
        logic          sunrise;
        now      = decode_bcd({2'b00, hr}) * 60 + decode_bcd({1'b0, mn});
        ring_now = 1'b0;
        pending  = 1'b0;
        for (i = 0; i < wac_pkg::NUM_ALARMS; i++) begin
            res[i]       = '0;
            res[i].index = 2'(i);
            res[i].lamp  = wac_pkg::LAMP_NONE;
            sunrise      = alarm_cfg[i][wac_pkg::ALM_SUNRISE];
            lead         = lead_minutes(alarm_cfg[i], now, wd);
            if (lead == 0) begin
                if (alarm_cfg[i][wac_pkg::ALM_RING]) begin
                    ring_now = 1'b1;
                end
                if (alarm_cfg[i][wac_pkg::ALM_SNOOZE]) begin
                    ring_now   = 1'b1;
                    snooze_seq = 1'b1;
                end
                if (sunrise && dusk_seen) begin
                    res[i].lamp = wac_pkg::LAMP_100;
                end
            end else if (lead == 7) begin
                if (sunrise && dusk_seen) begin
                    res[i].lamp = wac_pkg::LAMP_80;
                end
            end else if (lead == 15) begin
                if (sunrise && dusk_seen) begin
                    res[i].lamp = wac_pkg::LAMP_60;
                end
            end else if (lead == 22) begin
                if (sunrise && dusk_seen) begin
                    res[i].lamp = wac_pkg::LAMP_40;
                end
            end else if (lead == 30) begin
                // Sunrise start: darken flag on, lamp on at the lowest step
                if (sunrise) begin
                    dusk_seen   = 1'b1;
                    lamp_on     = 1'b1;
                    res[i].lamp = wac_pkg::LAMP_20;
                end
            end
            if (lead > 0) begin
                pending = 1'b1;
            end
        end

        // Ringing blanks the LEDs; snoozing re-rings and leaves the LEDs alone
        if (ring_now) begin
            led_pending = 1'b0;
            led_idle    = 1'b0;
        end else if (snooze_seq) begin
            for (i = 0; i < wac_pkg::NUM_ALARMS; i++) begin
                lag = lag_minutes(alarm_cfg[i], now, wd);
                if (lag == 4 || lag == 8 || lag == 12) begin
                    ring_now = 1'b1;
                end else if (lag == 15) begin
                    ring_now   = 1'b1;
                    snooze_seq = 1'b0;
                end
            end
        end else if (pending) begin
            led_pending = 1'b1;
            led_idle    = 1'b0;
        end else begin
            led_pending = 1'b0;
            led_idle    = 1'b1;
        end

        res[wac_pkg::NUM_ALARMS-1].last     = 1'b1;
        res[wac_pkg::NUM_ALARMS-1].ring     = ring_now;
        res[wac_pkg::NUM_ALARMS-1].snooze   = snooze_seq;
        res[wac_pkg::NUM_ALARMS-1].lamp_lit = lamp_on;
        res[wac_pkg::NUM_ALARMS-1].led_one  = led_pending;
        res[wac_pkg::NUM_ALARMS-1].led_two  = led_idle;
        for (i = 0; i < wac_pkg::NUM_ALARMS; i++) begin
            queued_alarm_results.push_back(res[i]);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, exp_val, $realtime);
        errors++;
    endtask

    // Follow writes and ticks, then check results; values sampled are those before the edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < wac_pkg::NUM_ALARMS; k++) begin
                alarm_cfg[k] = '0;
            end
            ring_now    = 1'b0;
            snooze_seq  = 1'b0;
            lamp_on     = 1'b0;
            dusk_seen   = 1'b0;
            led_pending = 1'b0;
            led_idle    = 1'b0;
            queued_alarm_results.delete();
        end else begin
            if (cfg_we) begin
                alarm_cfg[cfg_index] = cfg_data;
            end
            if (s_valid && s_ready && !s_alarms_off) begin
                predict_alarm_tick(s_hour_bcd, s_minute_bcd, s_weekday);
            end
            if (m_valid && m_ready) begin
                if (queued_alarm_results.size() == 0) begin
                    report_mismatch("result with no tick pending", m_alarm_index, -1);
                end else begin
                    want = queued_alarm_results.pop_front();
                    if (m_alarm_index !== want.index)
                        report_mismatch("alarm_index", m_alarm_index, want.index);
                    if (m_lamp_command !== want.lamp)
                        report_mismatch("lamp_command", m_lamp_command, want.lamp);
                    if (m_last_result !== want.last)
                        report_mismatch("last_result", m_last_result, want.last);
                    if (m_ringing !== want.ring)
                        report_mismatch("ringing", m_ringing, want.ring);
                    if (m_snooze_active !== want.snooze)
                        report_mismatch("snooze_active", m_snooze_active, want.snooze);
                    if (m_lamp_active !== want.lamp_lit)
                        report_mismatch("lamp_active", m_lamp_active, want.lamp_lit);
                    if (m_led_one !== want.led_one)
                        report_mismatch("led_one", m_led_one, want.led_one);
                    if (m_led_two !== want.led_two)
                        report_mismatch("led_two", m_led_two, want.led_two);
                end
            end
        end
        outstanding <= queued_alarm_results.size();
        fail_count  <= errors;
    end

endmodule

FILE: dv/weekly_alarm_checker_unit_test.sv
// Top of the weekly alarm checker test: clock, reset, alarm register writes and tick stimulus.
// Results are predicted and checked by alarm_tick_monitor; depends on wac_pkg and the block.
module weekly_alarm_checker_unit_test;

    localparam logic [1:0] REG_ALARM_ZERO  = 2'd0;
    localparam logic [1:0] REG_ALARM_ONE   = 2'd1;
    localparam logic [1:0] REG_ALARM_TWO   = 2'd2;
    localparam logic [1:0] REG_ALARM_THREE = 2'd3;
    localparam int         DAY_LEN         = 24 * 60;
    localparam int         SETTLE_CYCLES   = 12;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_we          = 1'b0;
    logic [1:0]  cfg_index       = '0;
    logic [26:0] cfg_data        = '0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [5:0]  s_hour_bcd      = '0;
    logic [6:0]  s_minute_bcd    = '0;
    logic [2:0]  s_weekday       = 3'd1;
    logic        s_alarms_off    = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [1:0]  m_alarm_index;
    logic [2:0]  m_lamp_command;
    logic        m_last_result;
    logic        m_ringing;
    logic        m_snooze_active;
    logic        m_lamp_active;
    logic        m_led_one;
    logic        m_led_two;
    int          fail_count;
    int          outstanding;

    int          send_idle_pct  = 26;
    int          recv_stall_pct = 76;
    int          ticks_sent     = 0;
    logic [26:0] alarm_plan [4];

    weekly_alarm_checker_unit u_dut (.*);

    alarm_tick_monitor u_monitor (.*);

    always #5 aclk = ~aclk;

    // Receiver stalls at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [7:0] to_bcd(input int n);
        return {4'(n / 10), 4'(n % 10)};
    endfunction

    function automatic int bcd_to_int(input logic [7:0] b);
        return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function automatic logic [26:0] make_alarm(input logic [7:0] hr, input logic [7:0] mn,
                                               input logic [6:0] days, input logic en,
                                               input logic ring, input logic snz,
                                               input logic sun);
        logic [26:0] a;
        a = '0;
        a[wac_pkg::ALM_MIN_LSB +: 8]  = mn;
        a[wac_pkg::ALM_HOUR_LSB +: 8] = hr;
        a[wac_pkg::ALM_DAYS_LSB +: 7] = days;
        a[wac_pkg::ALM_ENABLE]        = en;
        a[wac_pkg::ALM_RING]          = ring;
        a[wac_pkg::ALM_SNOOZE]        = snz;
        a[wac_pkg::ALM_SUNRISE]       = sun;
        return a;
    endfunction

    // Well-formed alarm within an hour after a cluster time, mostly enabled
    function automatic logic [26:0] random_alarm(input int base);
        int t;
        t = (base + $urandom_range(60)) % DAY_LEN;
        return make_alarm(to_bcd(t / 60), to_bcd(t % 60), 7'($urandom_range(1, 127)),
                          $urandom_range(9) != 0, 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [26:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        alarm_plan[idx] = value;
        @(posedge aclk);
    endtask

    task automatic load_alarms(input logic [26:0] a0, input logic [26:0] a1,
                               input logic [26:0] a2, input logic [26:0] a3);
        write_reg(REG_ALARM_ZERO, a0);
        write_reg(REG_ALARM_ONE, a1);
        write_reg(REG_ALARM_TWO, a2);
        write_reg(REG_ALARM_THREE, a3);
        cfg_we <= 1'b0;
    endtask

    // Offer one tick after a random gap and hold it until accepted
    task automatic send_tick(input logic [5:0] hr, input logic [6:0] mn,
                             input logic [2:0] wd, input logic off);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_hour_bcd   <= hr;
        s_minute_bcd <= mn;
        s_weekday    <= wd;
        s_alarms_off <= off;
        do @(posedge aclk); while (!s_ready);
        if (!off) begin
            ticks_sent++;
        end
    endtask

    // Hold the sender until every predicted result has come out
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Walk consecutive minutes through the window around one alarm
    task automatic run_walk(input int phase_end);
        int          k;
        int          cur;
        int          wd;
        int          len;
        int          n;
        logic [26:0] a;
        k   = $urandom_range(3);
        a   = alarm_plan[k];
        cur = (bcd_to_int(a[wac_pkg::ALM_HOUR_LSB +: 8]) * 60
               + bcd_to_int(a[wac_pkg::ALM_MIN_LSB +: 8])) % DAY_LEN;
        wd  = $urandom_range(1, 7);
        if ($urandom_range(4) != 0) begin
            for (n = 0; n < 7; n++) begin
                if (!a[wac_pkg::ALM_DAYS_LSB + wd - 1]) begin
                    wd = wd % 7 + 1;
                end
            end
        end
        cur = cur - $urandom_range(35);
        if (cur < 0) begin
            cur = cur + DAY_LEN;
            wd  = (wd == 1) ? 7 : wd - 1;
        end
        len = $urandom_range(6, 40);
        for (n = 0; n < len && ticks_sent < phase_end; n++) begin
            send_tick(6'(to_bcd(cur / 60)), 7'(to_bcd(cur % 60)), 3'(wd),
                      $urandom_range(99) < 4);
            cur++;
            if (cur == DAY_LEN) begin
                cur = 0;
                wd  = wd % 7 + 1;
            end
        end
    endtask

    // Mostly minute walks, some random ticks, one full drain halfway
    task automatic run_random_phase(input int quota);
        int   phase_end;
        logic drained;
        phase_end = ticks_sent + quota;
        drained   = 1'b0;
        while (ticks_sent < phase_end) begin
            if (!drained && ticks_sent >= phase_end - quota / 2) begin
                wait_for_results();
                drained = 1'b1;
            end
            if ($urandom_range(99) < 15) begin
                send_tick(6'($urandom_range(35)), 7'($urandom_range(89)),
                          3'($urandom_range(7)), $urandom_range(9) == 0);
            end else begin
                run_walk(phase_end);
            end
        end
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int base;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: full sunrise and snooze sequence, day wrap, weekday edge cases
        load_alarms(make_alarm(8'h07, 8'h00, 7'h7F, 1'b1, 1'b1, 1'b1, 1'b1),
                    make_alarm(8'h00, 8'h10, 7'h01, 1'b1, 1'b1, 1'b0, 1'b1),
                    make_alarm(8'h12, 8'h34, 7'h7F, 1'b0, 1'b1, 1'b1, 1'b1),
                    make_alarm(8'hFF, 8'hFF, 7'h40, 1'b1, 1'b1, 1'b0, 1'b0));
        send_tick(6'h06, 7'h30, 3'd3, 1'b0);
        send_tick(6'h06, 7'h38, 3'd3, 1'b0);
        send_tick(6'h06, 7'h45, 3'd3, 1'b0);
        send_tick(6'h06, 7'h53, 3'd3, 1'b0);
        send_tick(6'h07, 7'h00, 3'd3, 1'b0);
        send_tick(6'h07, 7'h02, 3'd3, 1'b1);
        send_tick(6'h07, 7'h04, 3'd3, 1'b0);
        send_tick(6'h07, 7'h08, 3'd3, 1'b0);
        send_tick(6'h07, 7'h12, 3'd3, 1'b0);
        send_tick(6'h07, 7'h15, 3'd3, 1'b0);
        send_tick(6'h07, 7'h16, 3'd3, 1'b0);
        send_tick(6'h23, 7'h40, 3'd7, 1'b0);
        send_tick(6'h23, 7'h48, 3'd0, 1'b0);
        send_tick(6'h06, 7'h30, 3'd0, 1'b0);
        send_tick(6'h00, 7'h10, 3'd7, 1'b0);
        send_tick(6'h00, 7'h10, 3'd1, 1'b0);
        send_tick(6'h23, 7'h59, 3'd7, 1'b0);
        send_tick(6'h00, 7'h00, 3'd1, 1'b0);
        send_tick(6'h1F, 7'h4F, 3'd2, 1'b0);
        send_tick(6'h0F, 7'h0F, 3'd4, 1'b0);
        send_tick(6'h23, 7'h59, 3'd6, 1'b1);
        send_tick(6'h20, 7'h40, 3'd5, 1'b0);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        // Sender idles lightly, receiver stalls heavily
        base = $urandom_range(DAY_LEN - 1);
        load_alarms(random_alarm(base), random_alarm(base), random_alarm(base),
                    random_alarm(base));
        run_random_phase(63);

        // Roles swapped, with a zeroed and a saturated register
        send_idle_pct  = 76;
        recv_stall_pct = 26;
        base = $urandom_range(DAY_LEN - 1);
        load_alarms('0, random_alarm(base), random_alarm(base), '1);
        run_random_phase(63);

        // No idling at all
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        base = $urandom_range(DAY_LEN - 1);
        load_alarms('1, '0, random_alarm(base), random_alarm(base));
        run_random_phase(63);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hard stop if the block stops responding
    initial begin : watchdog
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hdl/wac_pkg.sv
hdl/wac_eval.sv
hdl/weekly_alarm_checker_unit.sv
dv/alarm_tick_monitor.sv
dv/weekly_alarm_checker_unit_test.sv
